>>> rtl/f2h_pkg.sv
// ----------------------------------------------------------------------------
// f2h_pkg
// Shared types and constants for the binary32 / binary16 converter.
// ----------------------------------------------------------------------------
package f2h_pkg;

    localparam logic CMD_S2H = 1'b0;
    localparam logic CMD_H2S = 1'b1;

    localparam logic [15:0] HALF_INF      = 16'h7c00;
    localparam logic [12:0] DROP_HALFWAY  = 13'h1000;
    localparam logic [31:0] SGL_INF       = 32'h7f800000;
    localparam logic [7:0]  EXP_REBIAS    = 8'd112;

    // Decoded word after the first stage
    typedef struct packed {
        logic        cmd;
        logic        sign;
        logic [7:0]  exp;
        logic [22:0] mant;
        logic        exp_max;
        logic        exp_zero;
        logic        mant_zero;
    } dec_t;

    // Result before final rounding / assembly
    typedef struct packed {
        logic        cmd;
        logic [31:0] word;
        logic [10:0] hm;       // half mantissa before rounding increment
        logic        inc;      // add one to hm
        logic [5:0]  he;       // half exponent for normal path
        logic        norm;     // normal half path (needs carry handling)
        logic        sub;      // subnormal path: sign | (hm + inc)
    } mid_t;

endpackage

>>> rtl/fp32_fp16_converter.sv
// ----------------------------------------------------------------------------
// fp32_fp16_converter
// Stateless binary32 <-> binary16 converter, three-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_ready carry cmd and operand_word. cmd 0
//   converts a binary32 word to binary16 (result in bits 15..0, upper bits
//   zero); cmd 1 converts the binary16 word in bits 15..0 to binary32.
//   Output channel: out_valid / out_ready carry result_word.
//   Timing: out_valid rises once the word has passed the stage 1, 2 and 3
//   registers, and the word leaves on an edge with out_ready high; one word
//   per cycle is accepted while the output side keeps taking words.
//   Stage 1 decodes fields, stage 2 picks the case and rounding (and the
//   leading-zero count for half subnormals), stage 3 adds the round bit and
//   assembles the word.
//   Reset clears every stage valid bit; no word is in flight afterwards.
//   When the receiver stalls, the whole pipeline holds: each stage advances
//   only when the stage after it is empty or advancing, so no word is lost
//   or repeated.
// ----------------------------------------------------------------------------
module fp32_fp16_converter
    import f2h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] operand_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_word
);

    logic        v1_reg, v2_reg, v3_reg;
    logic        adv1, adv2, adv3;
    dec_t        s1_reg, s1_next;
    mid_t        s2_reg, s2_next;
    logic [31:0] s3_reg, s3_next;

    // Advance a stage when its successor is empty or moving on
    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // Stage 1: field decode
    always_comb
    begin
        s1_next.cmd  = cmd;
        if (cmd == CMD_H2S)
        begin
            s1_next.sign = operand_word[15];
            s1_next.exp  = {3'b000, operand_word[14:10]};
            s1_next.mant = {operand_word[9:0], 13'd0};
            s1_next.exp_max  = (operand_word[14:10] == 5'h1f);
            s1_next.exp_zero = (operand_word[14:10] == 5'h00);
            s1_next.mant_zero = (operand_word[9:0] == 10'd0);
        end
        else
        begin
            s1_next.sign = operand_word[31];
            s1_next.exp  = operand_word[30:23];
            s1_next.mant = operand_word[22:0];
            s1_next.exp_max  = (operand_word[30:23] == 8'hff);
            s1_next.exp_zero = (operand_word[30:23] == 8'h00);
            s1_next.mant_zero = (operand_word[22:0] == 23'd0);
        end
    end

    // Stage 2: case selection, rounding decision, normalization
    logic [8:0]  he_s;
    logic [23:0] full;
    logic [4:0]  sh;
    logic [23:0] shifted;
    logic [23:0] shifted_m1;
    logic [12:0] drop;
    logic [3:0]  lz;
    logic        lz_found;
    logic [9:0]  hm10;
    logic [9:0]  nm;

    always_comb
    begin
        he_s       = {1'b0, s1_reg.exp} - {1'b0, EXP_REBIAS};
        full       = {1'b1, s1_reg.mant};
        sh         = 5'd14 - he_s[4:0];
        shifted    = full >> sh;
        shifted_m1 = full >> (sh - 5'd1);
        drop       = s1_reg.mant[12:0];
        hm10       = s1_reg.mant[22:13];
        // leading-zero count of the half mantissa, first set bit from the top
        lz         = 4'd0;
        lz_found   = 1'b0;
        for (int i = 0; i < 10; i++)
        begin
            if (!lz_found && hm10[9 - i])
            begin
                lz       = 4'(i);
                lz_found = 1'b1;
            end
        end
        nm = 10'(hm10 << (lz + 4'd1));

        s2_next      = '0;
        s2_next.cmd  = s1_reg.cmd;
        if (s1_reg.cmd == CMD_H2S)
        begin
            if (s1_reg.exp_zero)
            begin
                if (s1_reg.mant_zero)
                    s2_next.word = {s1_reg.sign, 31'd0};
                else
                    s2_next.word = {s1_reg.sign, 8'(8'd113 - 8'(lz) - 8'd1),
                                    nm, 13'd0};
            end
            else if (s1_reg.exp_max)
                s2_next.word = SGL_INF | {s1_reg.sign, 8'd0, s1_reg.mant};
            else
                s2_next.word = {s1_reg.sign, 8'(s1_reg.exp + EXP_REBIAS),
                                s1_reg.mant};
        end
        else
        begin
            if (s1_reg.exp_max)
            begin
                if (s1_reg.mant_zero)
                    s2_next.word = {16'd0, {s1_reg.sign, 15'd0} | HALF_INF};
                else if (hm10 == 10'd0)
                    s2_next.word = {16'd0, {s1_reg.sign, 15'd0} | HALF_INF | 16'd1};
                else
                    s2_next.word = {16'd0, {s1_reg.sign, 15'd0} | HALF_INF
                                    | {6'd0, hm10}};
            end
            else if (s1_reg.exp_zero)
                s2_next.word = {16'd0, s1_reg.sign, 15'd0};
            else if (s1_reg.exp < 8'd102)
                s2_next.word = {16'd0, s1_reg.sign, 15'd0};
            else if (s1_reg.exp <= 8'd112)
            begin
                s2_next.sub  = 1'b1;
                s2_next.word = {16'd0, s1_reg.sign, 15'd0};
                s2_next.hm   = shifted[10:0];
                s2_next.inc  = shifted_m1[0];
            end
            else if (s1_reg.exp >= 8'd143)
                s2_next.word = {16'd0, {s1_reg.sign, 15'd0} | HALF_INF};
            else
            begin
                s2_next.norm = 1'b1;
                s2_next.word = {16'd0, s1_reg.sign, 15'd0};
                s2_next.hm   = {1'b0, hm10};
                s2_next.he   = he_s[5:0];
                s2_next.inc  = (drop > DROP_HALFWAY)
                             || (drop == DROP_HALFWAY && hm10[0]);
            end
        end
    end

    // Stage 3: round increment and assembly
    logic [10:0] hm_r;
    logic [5:0]  he_r;

    always_comb
    begin
        hm_r    = s2_reg.hm + {10'd0, s2_reg.inc};
        he_r    = s2_reg.he + {5'd0, hm_r[10]};
        s3_next = s2_reg.word;
        if (s2_reg.cmd == CMD_S2H)
        begin
            if (s2_reg.sub)
                s3_next = s2_reg.word | {21'd0, hm_r};
            else if (s2_reg.norm)
            begin
                if (he_r >= 6'd31)
                    s3_next = s2_reg.word | {16'd0, HALF_INF};
                else
                    s3_next = s2_reg.word | {16'd0, 1'b0, he_r[4:0], hm_r[9:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1) s1_reg <= s1_next;
        if (adv2) s2_reg <= s2_next;
        if (adv3) s3_reg <= s3_next;
    end

    assign out_valid   = v3_reg;
    assign result_word = s3_reg;

endmodule
